// ===== hdl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants for the speaker tone sequencer and its checker.
// ----------------------------------------------------------------------------
package sts_pkg;

  localparam int unsigned FIFO_DEPTH = 64;

  localparam int unsigned FREQ_W     = 16;
  localparam int unsigned MS_W       = 16;
  localparam int unsigned SLOTS_W    = 7;
  localparam int unsigned IN_DATA_W  = 32;
  localparam int unsigned OUT_DATA_W = 32;

  // timer input clock in hertz, dividend of the speaker divisor
  localparam int unsigned DIV_W = 21;
  localparam logic [DIV_W-1:0] PIT_CLOCK_HZ = 21'd1193180;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W);

  // length of one timer tick in milliseconds
  localparam logic [MS_W-1:0] TICK_MS = 16'd10;

  typedef enum logic {
    REQ_APPEND = 1'b0,
    REQ_TICK   = 1'b1
  } sts_req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_ABSORB,
    ST_DIVIDE,
    ST_FINISH
  } sts_state_e;

  // one result item, accepted in the lowest bit
  typedef struct packed {
    logic               tune_done;
    logic               half_free;
    logic [SLOTS_W-1:0] free_slots;
    logic [15:0]        divisor;
    logic               speaker_on;
    logic               accepted;
  } sts_result_t;

  localparam int unsigned RESULT_W = $bits(sts_result_t);

endpackage

// ===== hdl/speaker_tone_sequencer.sv =====
// ----------------------------------------------------------------------------
// speaker_tone_sequencer
// Tone packet ring buffer in a synchronous memory that paces a speaker timer.
// ----------------------------------------------------------------------------
// Path to the result register, output free: an append or a tick with nothing to play
// loads it from FINISH, a tick that pops the end marker reads the head first,
// and a sounding tick runs the 21-step divisor unit, after the head read when it
// pops a packet and after a memory read per follower while a short tone merges.
// Throughput: one item at a time, the next transfer is taken once the result
// sits in the output register. Reset clears state, pointers, counts, tone and valid, not data.

module speaker_tone_sequencer #(
  parameter int unsigned FifoDepth = sts_pkg::FIFO_DEPTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [sts_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,  // tone_freq, tone_ms
  input  logic                             s_axis_tuser_i,  // req_type
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // accepted, speaker_on, divisor, free_slots, half_free, tune_done, zero pad
  output logic [sts_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import sts_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);
  localparam logic [PtrW-1:0] LastIdx  = PtrW'(FifoDepth - 1);
  localparam logic [CntW-1:0] DepthCnt = CntW'(FifoDepth);
  localparam logic [CntW-1:0] HalfCnt  = CntW'(FifoDepth / 2);
  localparam logic [DIV_CNT_W-1:0] DivLast = DIV_CNT_W'(DIV_W - 1);

  // packet store
  logic [FREQ_W+MS_W-1:0] mem_q [FifoDepth];
  logic                   mem_we, mem_re;
  logic [PtrW-1:0]        mem_waddr, mem_raddr;
  logic [FREQ_W+MS_W-1:0] mem_wdata, mem_rdata_q;

  sts_state_e state_q, state_d;

  logic [PtrW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [CntW-1:0]   free_q, free_d;
  logic [FREQ_W-1:0] cur_q, cur_d;
  logic [MS_W-1:0]   rem_q, rem_d;
  logic [3:0]        sum_q, sum_d;

  logic [DIV_W-1:0]     dvd_q, dvd_d;
  logic [15:0]          drem_q, drem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic        res_acc_q, res_acc_d, res_spk_q, res_spk_d, res_done_q, res_done_d;
  logic [15:0] res_div_q, res_div_d;

  logic        m_valid_q, m_valid_d;
  sts_result_t m_data_q, m_data_d;

  // decodes
  logic              in_fire, out_free, is_tick, fifo_full, fifo_empty, more_after_pop;
  logic [FREQ_W-1:0] in_freq, head_f;
  logic [MS_W-1:0]   in_ms, head_d, rem_less, head_less;
  logic              head_marker;
  logic [PtrW-1:0]   wp_next, rp_next;
  logic [CntW-1:0]   free_inc;
  logic [MS_W:0]     sum_ext;
  logic [16:0]       trial, trial_diff;
  logic              trial_ge;
  logic [DIV_W-1:0]  quo_fin;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_fire   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free  = ~m_valid_q | m_axis_tready_i;
  assign is_tick   = (s_axis_tuser_i == REQ_TICK);
  assign in_freq   = s_axis_tdata_i[FREQ_W-1:0];
  assign in_ms     = s_axis_tdata_i[FREQ_W+MS_W-1:FREQ_W];

  assign fifo_full      = (free_q == '0);
  assign fifo_empty     = (free_q == DepthCnt);
  assign free_inc       = free_q + CntW'(1);
  assign more_after_pop = (free_inc != DepthCnt);
  assign wp_next        = (wp_q == LastIdx) ? '0 : wp_q + PtrW'(1);
  assign rp_next        = (rp_q == LastIdx) ? '0 : rp_q + PtrW'(1);

  assign head_f      = mem_rdata_q[FREQ_W+MS_W-1:MS_W];
  assign head_d      = mem_rdata_q[MS_W-1:0];
  assign head_marker = (mem_rdata_q == '0);
  assign rem_less    = rem_q - TICK_MS;
  assign head_less   = head_d - TICK_MS;
  assign sum_ext     = {{(MS_W-3){1'b0}}, sum_q} + {1'b0, head_d};

  // one restoring division step per cycle
  assign trial      = {drem_q, dvd_q[DIV_W-1]};
  assign trial_ge   = (trial >= {1'b0, cur_q});
  assign trial_diff = trial - {1'b0, cur_q};
  assign quo_fin    = {dvd_q[DIV_W-2:0], trial_ge};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (!is_tick) begin
            state_d = ST_FINISH;
          end else if (rem_q >= TICK_MS) begin
            state_d = ST_DIVIDE;
          end else if (!fifo_empty) begin
            state_d = ST_HEAD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_HEAD: begin
        if (head_marker) begin
          state_d = ST_FINISH;
        end else if (head_d >= TICK_MS || !more_after_pop) begin
          state_d = ST_DIVIDE;
        end else begin
          state_d = ST_ABSORB;
        end
      end
      ST_ABSORB: begin
        if (!head_marker && sum_ext < {1'b0, TICK_MS} && more_after_pop) begin
          state_d = ST_ABSORB;
        end else begin
          state_d = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (cnt_q == DivLast) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    wp_d       = wp_q;
    rp_d       = rp_q;
    free_d     = free_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    sum_d      = sum_q;
    dvd_d      = dvd_q;
    drem_d     = drem_q;
    cnt_d      = cnt_q;
    res_acc_d  = res_acc_q;
    res_spk_d  = res_spk_q;
    res_div_d  = res_div_q;
    res_done_d = res_done_q;
    m_data_d   = m_data_q;
    m_valid_d  = m_valid_q & ~m_axis_tready_i;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = wp_q;
    mem_raddr  = rp_q;
    mem_wdata  = {in_freq, in_ms};

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          res_acc_d  = 1'b0;
          res_spk_d  = 1'b0;
          res_div_d  = '0;
          res_done_d = 1'b0;
          if (!is_tick) begin
            if (!fifo_full) begin
              mem_we    = 1'b1;
              wp_d      = wp_next;
              free_d    = free_q - CntW'(1);
              res_acc_d = 1'b1;
            end
          end else if (rem_q >= TICK_MS) begin
            rem_d = (rem_less < TICK_MS) ? '0 : rem_less;
          end else if (!fifo_empty) begin
            mem_re = 1'b1;
          end else begin
            cur_d = '0;
          end
        end
      end
      ST_HEAD: begin
        rp_d   = rp_next;
        free_d = free_inc;
        if (head_marker) begin
          cur_d      = '0;
          rem_d      = '0;
          res_done_d = 1'b1;
        end else if (head_d >= TICK_MS) begin
          cur_d = head_f;
          rem_d = (head_less < TICK_MS) ? '0 : head_less;
        end else begin
          // short tone, start soaking up the following packets
          cur_d = head_f;
          rem_d = '0;
          sum_d = head_d[3:0];
          if (more_after_pop) begin
            mem_re    = 1'b1;
            mem_raddr = rp_next;
          end
        end
      end
      ST_ABSORB: begin
        if (!head_marker) begin
          if (sum_ext == {1'b0, TICK_MS}) begin
            rp_d   = rp_next;
            free_d = free_inc;
          end else if (sum_ext > {1'b0, TICK_MS}) begin
            // leftover stays in the packet where the tick runs out
            mem_we    = 1'b1;
            mem_waddr = rp_q;
            mem_wdata = {head_f, sum_ext[MS_W-1:0] - TICK_MS};
          end else begin
            rp_d   = rp_next;
            free_d = free_inc;
            sum_d  = sum_ext[3:0];
            if (more_after_pop) begin
              mem_re    = 1'b1;
              mem_raddr = rp_next;
            end
          end
        end
      end
      ST_DIVIDE: begin
        dvd_d  = quo_fin;
        drem_d = trial_ge ? trial_diff[15:0] : trial[15:0];
        cnt_d  = cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DivLast) begin
          res_spk_d = (cur_q != '0);
          if (cur_q == '0) begin
            res_div_d = '0;
          end else if (quo_fin[DIV_W-1:16] != '0) begin
            res_div_d = '1;
          end else begin
            res_div_d = quo_fin[15:0];
          end
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          m_valid_d           = 1'b1;
          m_data_d.accepted   = res_acc_q;
          m_data_d.speaker_on = res_spk_q;
          m_data_d.divisor    = res_div_q;
          m_data_d.free_slots = SLOTS_W'(free_q);
          m_data_d.half_free  = (free_q >= HalfCnt);
          m_data_d.tune_done  = res_done_q;
        end
      end
      default: ;
    endcase

    if (state_d == ST_DIVIDE && state_q != ST_DIVIDE) begin
      dvd_d  = PIT_CLOCK_HZ;
      drem_d = '0;
      cnt_d  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      free_q    <= DepthCnt;
      cur_q     <= '0;
      rem_q     <= '0;
      sum_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      free_q    <= free_d;
      cur_q     <= cur_d;
      rem_q     <= rem_d;
      sum_q     <= sum_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q      <= dvd_d;
    drem_q     <= drem_d;
    res_acc_q  <= res_acc_d;
    res_spk_q  <= res_spk_d;
    res_div_q  <= res_div_d;
    res_done_q <= res_done_d;
    m_data_q   <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-RESULT_W){1'b0}}, m_data_q};

endmodule

// ===== hdl/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks on the result stream of the speaker tone sequencer.
// ----------------------------------------------------------------------------
module sts_checker #(
  parameter int unsigned FifoDepth = sts_pkg::FIFO_DEPTH
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           m_axis_tvalid_i,
  input logic                           m_axis_tready_i,
  input logic [sts_pkg::OUT_DATA_W-1:0] m_axis_tdata_i
);
  import sts_pkg::*;

  localparam logic SlotsFit = (FifoDepth < 128);

  sts_result_t res;
  assign res = sts_result_t'(m_axis_tdata_i[RESULT_W-1:0]);

  // a stalled result must not move
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && !m_axis_tready_i |=> m_axis_tvalid_i && $stable(m_axis_tdata_i))
    else $error("result changed while stalled");

  // only an append can report a stored packet
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> !(res.accepted && (res.speaker_on || res.tune_done)))
    else $error("append result carries tick fields");

  // the speaker is on exactly when the divisor is nonzero (a sounding tone gives at least 18)
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> res.speaker_on == (res.divisor != '0))
    else $error("divisor and speaker enable disagree");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && res.tune_done |-> !res.speaker_on)
    else $error("speaker on at end of tune");

  a_slots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i && SlotsFit |->
      (32'(res.free_slots) <= FifoDepth) &&
      (res.half_free == (32'(res.free_slots) >= FifoDepth / 2)))
    else $error("free slot count out of range");

endmodule

bind speaker_tone_sequencer sts_checker #(
  .FifoDepth (FifoDepth)
) u_sts_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_i  (m_axis_tdata_o)
);
